// ===== rtl/ustd_pkg.sv =====
// Shared constants, tables and types for the seconds-to-date pipeline.
package ustd_pkg;

  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned SEC_MIN   = 60;

  localparam logic [25:0] GREG_BIAS   = 26'd102032;
  localparam int unsigned GREG_CYCLE  = 146097;
  localparam logic [8:0]  GREG_ADJ    = 9'd15;
  localparam logic [23:0] JD_OFFSET   = 24'd2442113;
  localparam logic [28:0] YEAR_BIAS   = 29'd2442;
  localparam int unsigned YEAR_DIV    = 7305;
  localparam logic [23:0] YEAR_DAYS   = 24'd365;
  localparam logic [19:0] MONTH_SCALE = 20'd1000;
  localparam int unsigned MONTH_DIV   = 30601;
  localparam logic [15:0] YEAR_BASE   = 16'd4716;
  localparam logic [3:0]  MONTH_WRAP  = 4'd14;
  localparam logic [3:0]  MONTH_LATE  = 4'd13;
  localparam int unsigned CENT_DIV    = 100;
  localparam logic [11:0] ZEL_CENT    = 12'd5;
  localparam logic [11:0] ZEL_BIAS    = 12'd5;
  localparam int unsigned WEEK_DIV    = 7;

  // Days before each shifted month: 30 * e + floor(601 * e / 1000).
  localparam logic [8:0] MONTH_OFFS [16] = '{
    9'd0,   9'd30,  9'd61,  9'd91,  9'd122, 9'd153, 9'd183, 9'd214,
    9'd244, 9'd275, 9'd306, 9'd336, 9'd367, 9'd397, 9'd428, 9'd459
  };

  // Month term of the weekday formula: floor(26 * (m + 1) / 10).
  localparam logic [5:0] ZEL_MONTH [16] = '{
    6'd2,  6'd5,  6'd7,  6'd10, 6'd13, 6'd15, 6'd18, 6'd20,
    6'd23, 6'd26, 6'd28, 6'd31, 6'd33, 6'd36, 6'd39, 6'd41
  };

  typedef struct packed {
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } hms_t;

endpackage

// ===== rtl/unix_seconds_to_date_unit.sv =====
// Top level: Unix seconds to Gregorian date, time of day and weekday.
//
// A word enters on unix_seconds when start is high; busy is always low, so a
// new word may be offered in every clock cycle.
// Each word gives one result: done is high for one
// cycle with year, month, day, hours, minutes, seconds and weekday valid.
// Results leave in the order the words came in, one per cycle at most.
// The depth comes mostly from the chain of constant dividers: two for seconds
// to days, two for the time of day, then five in the calendar pipeline, each
// with a reciprocal multiply stage and a correction stage. Six register stages
// for the calendar sums between those dividers, and the output register, add
// the rest of the depth.
// Reset clears all valid bits; words in flight are dropped and done stays low
// until new words have passed through.
// The receiver cannot stall the block, and no result is ever held back.
module unix_seconds_to_date_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] unix_seconds,
  output logic        busy,
  output logic        done,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic [2:0]  weekday
);

  localparam int LATENCY = 25;

  logic           v1;
  logic [7:0]     q1;
  logic [9:0]     r1;
  logic [22:0]    s1;

  logic           v2;
  logic [16:0]    q2;
  logic [9:0]     r2;
  logic [14:0]    s2;
  logic [23:0]    days2;
  logic [16:0]    tod2;

  logic           v3;
  logic [11:0]    q3;
  logic [5:0]     r3;
  logic [23:0]    s3;

  logic           v4;
  logic [5:0]     q4;
  logic [5:0]     r4;
  logic [29:0]    s4;
  ustd_pkg::hms_t hms4;

  logic           vd;
  logic [15:0]    yd;
  logic [3:0]     md;
  logic [4:0]     dd;
  logic [2:0]     wd;
  ustd_pkg::hms_t hmsd;

  assign busy = 1'b0;

  ustd_cdiv #(.W(17), .DIV(ustd_pkg::DAY_ODD), .SW(23)) u_div_day_hi (
    .clk(clk), .rst(rst), .in_vld(start), .x(unix_seconds[39:23]),
    .side_in(unix_seconds[22:0]),
    .out_vld(v1), .q(q1), .r(r1), .side_out(s1)
  );

  ustd_cdiv #(.W(26), .DIV(ustd_pkg::DAY_ODD), .SW(15)) u_div_day_lo (
    .clk(clk), .rst(rst), .in_vld(v1), .x({r1, s1[22:ustd_pkg::DAY_SHIFT]}),
    .side_in({q1, s1[ustd_pkg::DAY_SHIFT-1:0]}),
    .out_vld(v2), .q(q2), .r(r2), .side_out(s2)
  );

  assign days2 = {s2[14:7], q2[15:0]};
  assign tod2  = {r2, s2[6:0]};

  ustd_cdiv #(.W(17), .DIV(ustd_pkg::SEC_MIN), .SW(24)) u_div_sec (
    .clk(clk), .rst(rst), .in_vld(v2), .x(tod2), .side_in(days2),
    .out_vld(v3), .q(q3), .r(r3), .side_out(s3)
  );

  ustd_cdiv #(.W(11), .DIV(ustd_pkg::SEC_MIN), .SW(30)) u_div_min (
    .clk(clk), .rst(rst), .in_vld(v3), .x(q3[10:0]), .side_in({s3, r3}),
    .out_vld(v4), .q(q4), .r(r4), .side_out(s4)
  );

  assign hms4.hours   = q4[4:0];
  assign hms4.minutes = r4;
  assign hms4.seconds = s4[5:0];

  ustd_date u_date (
    .clk(clk), .rst(rst), .in_vld(v4), .days(s4[29:6]), .hms_in(hms4),
    .out_vld(vd), .year(yd), .month(md), .day(dd), .weekday(wd), .hms_out(hmsd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vd;
    end
    year    <= yd;
    month   <= md;
    day     <= dd;
    weekday <= wd;
    hours   <= hmsd.hours;
    minutes <= hmsd.minutes;
    seconds <= hmsd.seconds;
  end

  a_word_out: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(LATENCY) done)
    else $error("accepted word gave no result");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LATENCY))
    else $error("result without an accepted word");

  a_fields_legal: assert property (@(posedge clk) disable iff (rst)
    done |-> (month != 4'd0) && (month <= 4'd12) && (day != 5'd0)
             && (weekday != 3'd0) && (hours <= 5'd23) && (minutes <= 6'd59)
             && (seconds <= 6'd59))
    else $error("result field out of range");

endmodule

// ===== rtl/ustd_cdiv.sv =====
// Two-stage division of an unsigned word by a constant, with a side word carried along.
module ustd_cdiv #(
  parameter int W   = 16,
  parameter int DIV = 7,
  parameter int SW  = 1,
  localparam longint unsigned MV = (64'd1 << W) / DIV,
  localparam int MW = $clog2(MV + 1),
  localparam int RW = $clog2(DIV)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [W-1:0]  x,
  input  logic [SW-1:0] side_in,
  output logic          out_vld,
  output logic [MW-1:0] q,
  output logic [RW-1:0] r,
  output logic [SW-1:0] side_out
);

  localparam logic [MW-1:0] RECIP = MW'(MV);
  localparam logic [W-1:0]  DIV_W = W'(DIV);
  localparam logic [RW:0]   DIV_R = (RW + 1)'(DIV);

  logic [W+MW-1:0] prod;
  logic            vld1;
  logic [W-1:0]    x1;
  logic [MW-1:0]   q1;
  logic [SW-1:0]   side1;
  logic [W-1:0]    qmul;
  logic [W-1:0]    rem;
  logic [RW:0]     rem_n;
  logic            fix;

  assign prod = (W + MW)'(x) * (W + MW)'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1 <= 1'b0;
    end else begin
      vld1 <= in_vld;
    end
    x1    <= x;
    q1    <= prod[W+MW-1:W];
    side1 <= side_in;
  end

  assign qmul  = W'(q1) * DIV_W;
  assign rem   = x1 - qmul;
  assign rem_n = rem[RW:0];
  assign fix   = (rem_n >= DIV_R);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= vld1;
    end
    q        <= fix ? q1 + 1'b1 : q1;
    r        <= fix ? RW'(rem_n - DIV_R) : rem_n[RW-1:0];
    side_out <= side1;
  end

endmodule

// ===== rtl/ustd_date.sv =====
// Day count to year, month, day and weekday, as a pipeline of constant divisions, with the time of day carried along.
module ustd_date (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_vld,
  input  logic [23:0]       days,
  input  ustd_pkg::hms_t    hms_in,
  output logic              out_vld,
  output logic [15:0]       year,
  output logic [3:0]        month,
  output logic [4:0]        day,
  output logic [2:0]        weekday,
  output ustd_pkg::hms_t    hms_out
);

  localparam int HW = $bits(ustd_pkg::hms_t);

  logic [25:0]   xa;
  logic          va;
  logic [8:0]    qa;
  logic [23+HW:0] sa;
  logic [8:0]    a;

  logic          vb;
  logic [23:0]   b;
  ustd_pkg::hms_t hb;

  logic          vc;
  logic [28:0]   xc;
  logic [23:0]   bc;
  ustd_pkg::hms_t hc;

  logic          vc2;
  logic [16:0]   qc;
  logic [23+HW:0] sc;
  logic [15:0]   c;
  logic [23:0]   d_full;

  logic          vd;
  logic [15:0]   cd;
  logic [9:0]    dd;
  ustd_pkg::hms_t hd;

  logic          ve;
  logic [19:0]   xe;
  logic [15:0]   ce;
  logic [9:0]    de;
  ustd_pkg::hms_t he;

  logic          vf;
  logic [5:0]    qf;
  logic [25+HW:0] sf;
  logic [3:0]    e;
  logic [15:0]   cf;
  logic [9:0]    df;
  logic [9:0]    f_full;
  logic          late;
  logic [15:0]   yz_next;

  logic          vg;
  logic [15:0]   yg;
  logic [3:0]    mg;
  logic [4:0]    fg;
  logic [3:0]    mzg;
  logic [15:0]   yzg;
  ustd_pkg::hms_t hg;

  logic          vh;
  logic [9:0]    cent;
  logic [6:0]    yoc;
  logic [28+HW:0] sh;
  logic [15:0]   yh;
  logic [3:0]    mh;
  logic [4:0]    fh;
  logic [3:0]    mzh;
  ustd_pkg::hms_t hh;
  logic [11:0]   h_next;

  logic          vi;
  logic [11:0]   hi;
  logic [24+HW:0] si;

  logic [2:0]    rj;
  logic [24+HW:0] sj;

  assign xa = {days, 2'b00} + ustd_pkg::GREG_BIAS;

  ustd_cdiv #(.W(26), .DIV(ustd_pkg::GREG_CYCLE), .SW(24 + HW)) u_div_cycle (
    .clk(clk), .rst(rst), .in_vld(in_vld), .x(xa), .side_in({days, hms_in}),
    .out_vld(va), .q(qa), .r(), .side_out(sa)
  );

  assign a = qa + ustd_pkg::GREG_ADJ;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      vc <= 1'b0;
    end else begin
      vb <= va;
      vc <= vb;
    end
    b  <= sa[23+HW:HW] + ustd_pkg::JD_OFFSET + 24'(a) - 24'(a[8:2]);
    hb <= sa[HW-1:0];
    xc <= 29'({b, 4'b0000}) + 29'({b, 2'b00}) - ustd_pkg::YEAR_BIAS;
    bc <= b;
    hc <= hb;
  end

  ustd_cdiv #(.W(29), .DIV(ustd_pkg::YEAR_DIV), .SW(24 + HW)) u_div_year (
    .clk(clk), .rst(rst), .in_vld(vc), .x(xc), .side_in({bc, hc}),
    .out_vld(vc2), .q(qc), .r(), .side_out(sc)
  );

  assign c      = qc[15:0];
  assign d_full = sc[23+HW:HW] - 24'(c) * ustd_pkg::YEAR_DAYS - 24'(c[15:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
      ve <= 1'b0;
    end else begin
      vd <= vc2;
      ve <= vd;
    end
    cd <= c;
    dd <= d_full[9:0];
    hd <= sc[HW-1:0];
    xe <= 20'(dd) * ustd_pkg::MONTH_SCALE;
    ce <= cd;
    de <= dd;
    he <= hd;
  end

  ustd_cdiv #(.W(20), .DIV(ustd_pkg::MONTH_DIV), .SW(26 + HW)) u_div_month (
    .clk(clk), .rst(rst), .in_vld(ve), .x(xe), .side_in({ce, de, he}),
    .out_vld(vf), .q(qf), .r(), .side_out(sf)
  );

  assign e       = qf[3:0];
  assign cf      = sf[25+HW:10+HW];
  assign df      = sf[9+HW:HW];
  assign f_full  = df - 10'(ustd_pkg::MONTH_OFFS[e]);
  assign late    = (e >= ustd_pkg::MONTH_WRAP);
  assign yz_next = cf - ustd_pkg::YEAR_BASE;

  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else begin
      vg <= vf;
    end
    yzg <= yz_next;
    yg  <= late ? yz_next + 16'd1 : yz_next;
    mg  <= late ? e - ustd_pkg::MONTH_LATE : e - 4'd1;
    mzg <= e - 4'd1;
    fg  <= f_full[4:0];
    hg  <= sf[HW-1:0];
  end

  ustd_cdiv #(.W(16), .DIV(ustd_pkg::CENT_DIV), .SW(29 + HW)) u_div_cent (
    .clk(clk), .rst(rst), .in_vld(vg), .x(yzg), .side_in({yg, mg, fg, mzg, hg}),
    .out_vld(vh), .q(cent), .r(yoc), .side_out(sh)
  );

  assign yh  = sh[28+HW:13+HW];
  assign mh  = sh[12+HW:9+HW];
  assign fh  = sh[8+HW:4+HW];
  assign mzh = sh[3+HW:HW];
  assign hh  = sh[HW-1:0];

  assign h_next = 12'(fh) + 12'(ustd_pkg::ZEL_MONTH[mzh]) + 12'(yoc) + 12'(yoc[6:2])
                + 12'(cent) * ustd_pkg::ZEL_CENT + 12'(cent[9:2]) + ustd_pkg::ZEL_BIAS;

  always_ff @(posedge clk) begin
    if (rst) begin
      vi <= 1'b0;
    end else begin
      vi <= vh;
    end
    hi <= h_next;
    si <= {yh, mh, fh, hh};
  end

  ustd_cdiv #(.W(12), .DIV(ustd_pkg::WEEK_DIV), .SW(25 + HW)) u_div_week (
    .clk(clk), .rst(rst), .in_vld(vi), .x(hi), .side_in(si),
    .out_vld(out_vld), .q(), .r(rj), .side_out(sj)
  );

  assign year    = sj[24+HW:9+HW];
  assign month   = sj[8+HW:5+HW];
  assign day     = sj[4+HW:HW];
  assign hms_out = sj[HW-1:0];
  assign weekday = rj + 3'd1;

endmodule

// ===== verif/date_check_pkg.sv =====
`timescale 1ns / 1ps
// Calendar prediction and result scoreboard for the seconds-to-date testbench.
package date_check_pkg;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [2:0]  weekday;
  } calendar_t;

  function automatic calendar_t to_calendar(input logic [39:0] stamp);
    longint unsigned t, days, a, b, c, d, e, f, m, y, cent, yoc, h;
    calendar_t r;
    t = stamp;
    r.seconds = 6'(t % 60);
    t = t / 60;
    r.minutes = 6'(t % 60);
    t = t / 60;
    r.hours = 5'(t % 24);
    days = t / 24;
    a = (4 * days + 102032) / 146097 + 15;
    b = days + 2442113 + a - a / 4;
    c = (20 * b - 2442) / 7305;
    d = b - 365 * c - c / 4;
    e = (d * 1000) / 30601;
    f = d - e * 30 - (e * 601) / 1000;
    if (e <= 13) begin
      c = c - 4716;
      e = e - 1;
    end else begin
      c = c - 4715;
      e = e - 13;
    end
    r.year = 16'(c);
    r.month = 4'(e);
    r.day = 5'(f);
    // Zeller's congruence counts January and February with the previous year.
    m = e;
    y = c;
    if (m <= 2) begin
      m = m + 12;
      y = y - 1;
    end
    cent = y / 100;
    yoc = y % 100;
    h = f + (26 * (m + 1)) / 10 + yoc + yoc / 4 + 5 * cent + cent / 4;
    r.weekday = 3'((h + 5) % 7 + 1);
    return r;
  endfunction

  class date_scoreboard;
    calendar_t expected_q[$];
    int mismatches;

    function new();
      mismatches = 0;
    endfunction

    task report(input string msg);
      $display("%0t: %s", $time, msg);
      mismatches++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void note_stamp(input logic [39:0] stamp);
      expected_q.push_back(to_calendar(stamp));
    endfunction

    task check_date(input calendar_t got);
      calendar_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %0d-%0d-%0d %0d:%0d:%0d wd %0d", got.year,
                         got.month, got.day, got.hours, got.minutes, got.seconds, got.weekday));
        return;
      end
      want = expected_q.pop_front();
      if (got.year !== want.year)
        report($sformatf("year %0d, expected %0d", got.year, want.year));
      if (got.month !== want.month)
        report($sformatf("month %0d, expected %0d", got.month, want.month));
      if (got.day !== want.day)
        report($sformatf("day %0d, expected %0d", got.day, want.day));
      if (got.hours !== want.hours)
        report($sformatf("hours %0d, expected %0d", got.hours, want.hours));
      if (got.minutes !== want.minutes)
        report($sformatf("minutes %0d, expected %0d", got.minutes, want.minutes));
      if (got.seconds !== want.seconds)
        report($sformatf("seconds %0d, expected %0d", got.seconds, want.seconds));
      if (got.weekday !== want.weekday)
        report($sformatf("weekday %0d, expected %0d", got.weekday, want.weekday));
    endtask

    task flush_leftovers();
      while (expected_q.size() != 0) begin
        report($sformatf("result for %0d-%0d-%0d never arrived", expected_q[0].year,
                         expected_q[0].month, expected_q[0].day));
        void'(expected_q.pop_front());
      end
    endtask
  endclass

endpackage

// ===== verif/unix_seconds_to_date_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the Unix seconds to calendar date converter.
module unix_seconds_to_date_unit_tb;
  import date_check_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [39:0] unix_seconds = '0;
  logic        busy;
  logic        done;
  logic [15:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [2:0]  weekday;

  date_scoreboard sb = new();
  bit no_idle = 1'b0;

  unix_seconds_to_date_unit dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .unix_seconds(unix_seconds),
    .busy(busy),
    .done(done),
    .year(year),
    .month(month),
    .day(day),
    .hours(hours),
    .minutes(minutes),
    .seconds(seconds),
    .weekday(weekday)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin : monitor
    calendar_t seen;
    if (!rst) begin
      if (done) begin
        seen = {year, month, day, hours, minutes, seconds, weekday};
        sb.check_date(seen);
      end
      if (start && !busy)
        sb.note_stamp(unix_seconds);
    end
  end

  function automatic logic [39:0] random_stamp();
    return {8'($urandom_range(0, 255)), 32'($urandom)};
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55)
      return 0;
    if (r < 85)
      return $urandom_range(1, 3);
    if (r < 97)
      return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input logic [39:0] value, input int gap);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      unix_seconds <= random_stamp();
    end
    @(negedge clk);
    start <= 1'b1;
    unix_seconds <= value;
    @(posedge clk);
    while (busy)
      @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [39:0] directed_words[$];
    longint unsigned days, offset;
    logic [39:0] value;
    int kind, waited;
    directed_words = '{
      40'd0, 40'hFF_FFFF_FFFF, 40'd59, 40'd60, 40'd3599, 40'd3600, 40'd86399, 40'd86400,
      40'h55_5555_5555, 40'hAA_AAAA_AAAA, 40'd2147483647, 40'd4294967295, 40'd4294967296,
      40'd946684799, 40'd951782400, 40'd951868800, 40'd4107542399, 40'd4107542400,
      40'd172800, 40'd259200, 40'd345600, 40'd432000, 40'd518400
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed_words[i])
      send_word(directed_words[i], next_gap());
    drain();
    for (int n = 0; n < 700; n++) begin
      if (n % 100 == 0)
        no_idle = ($urandom_range(0, 2) == 0);
      if (n == 250 || n == 500)
        drain();
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        value = random_stamp();
      end else if (kind < 8) begin
        // Day-based words, often near midnight, test month, year and leap bounds.
        if (kind < 6)
          days = $urandom_range(0, 12725828);
        else
          days = $urandom_range(0, 150000);
        case ($urandom_range(0, 2))
          0: offset = 0;
          1: offset = 86399;
          default: offset = $urandom_range(0, 86399);
        endcase
        value = 40'(days * 86400 + offset);
      end else begin
        value = 40'($urandom);
      end
      send_word(value, next_gap());
    end
    @(negedge clk);
    start <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 400) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    sb.flush_leftovers();
    if (sb.mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    #5000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ustd_pkg.sv
rtl/ustd_cdiv.sv
rtl/ustd_date.sv
rtl/unix_seconds_to_date_unit.sv
verif/date_check_pkg.sv
verif/unix_seconds_to_date_unit_tb.sv
